// File: rtl/wfhm_pkg.sv
`default_nettype none

package wfhm_pkg;

	localparam int MAX_WHEELS_DEF = 8;
	localparam int COUNT_BITS_DEF = 16;

	localparam int WHEEL_W    = 3;
	localparam int RES_W      = 32;
	localparam int MAG_W      = 31;
	localparam int CNT_OUT_W  = 16;
	localparam int SAMP_W     = 16;
	localparam int NWHEEL_W   = 4;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	typedef enum logic [1:0] {
		CMD_UPDATE = 2'd0,
		CMD_RESET  = 2'd1,
		CMD_QUERY  = 2'd2,
		CMD_SPARE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STATUS_OK       = 2'd0,
		STATUS_DEGRADED = 2'd1,
		STATUS_RANGE    = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WHEELS   = 3'd0,
		REG_FAULT_TH = 3'd1,
		REG_RECOV_TH = 3'd2,
		REG_FAULT_N  = 3'd3,
		REG_RECOV_N  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [NWHEEL_W-1:0] wheels_in_use;
		logic [MAG_W-1:0]    fault_threshold;
		logic [MAG_W-1:0]    recovery_threshold;
		logic [SAMP_W-1:0]   fault_samples;
		logic [SAMP_W-1:0]   recovery_samples;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		wheels_in_use:      4'd4,
		fault_threshold:    31'd32768,
		recovery_threshold: 31'd13107,
		fault_samples:      16'd3,
		recovery_samples:   16'd5
	};

endpackage

`default_nettype wire

// File: rtl/wfhm_cfg_regs.sv
`default_nettype none

module wfhm_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [wfhm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wfhm_pkg::CFG_DATA_W-1:0]     cfg_data,
	output wfhm_pkg::cfg_t                           cfg
);

	wfhm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= wfhm_pkg::CFG_RESET;
		end else if (cfg_wr_en) begin
			unique case (wfhm_pkg::cfg_reg_t'(cfg_index))
				wfhm_pkg::REG_WHEELS: begin
					cfg_q.wheels_in_use <= cfg_data[wfhm_pkg::NWHEEL_W-1:0];
				end
				wfhm_pkg::REG_FAULT_TH: begin
					cfg_q.fault_threshold <= cfg_data[wfhm_pkg::MAG_W-1:0];
				end
				wfhm_pkg::REG_RECOV_TH: begin
					cfg_q.recovery_threshold <= cfg_data[wfhm_pkg::MAG_W-1:0];
				end
				wfhm_pkg::REG_FAULT_N: begin
					cfg_q.fault_samples <= cfg_data[wfhm_pkg::SAMP_W-1:0];
				end
				wfhm_pkg::REG_RECOV_N: begin
					cfg_q.recovery_samples <= cfg_data[wfhm_pkg::SAMP_W-1:0];
				end
				default: begin
					// writes beyond the register list are dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/wfhm_step.sv
`default_nettype none

module wfhm_step #(
	parameter int COUNT_BITS = wfhm_pkg::COUNT_BITS_DEF
) (
	input  wire wfhm_pkg::cfg_t                   cfg,
	input  wire wfhm_pkg::cmd_t                   cmd,
	input  wire logic [wfhm_pkg::RES_W-1:0]       residual,
	input  wire logic                             sensor_ok,
	input  wire logic                             reset_healthy,
	input  wire logic                             faulted_cur,
	input  wire logic [COUNT_BITS-1:0]            fault_ev_cur,
	input  wire logic [COUNT_BITS-1:0]            recov_ev_cur,
	input  wire logic [wfhm_pkg::MAG_W-1:0]       mag_cur,
	output logic                                  faulted_nxt,
	output logic [COUNT_BITS-1:0]                 fault_ev_nxt,
	output logic [COUNT_BITS-1:0]                 recov_ev_nxt,
	output logic [wfhm_pkg::MAG_W-1:0]            mag_nxt
);

	localparam int CW = (COUNT_BITS > wfhm_pkg::SAMP_W) ? COUNT_BITS : wfhm_pkg::SAMP_W;

	logic [CW-1:0]                  cnt_max_w;
	logic [CW-1:0]                  fault_n_w;
	logic [CW-1:0]                  recov_n_w;
	logic [COUNT_BITS-1:0]          fault_load;
	logic [COUNT_BITS-1:0]          fault_inc;
	logic [COUNT_BITS-1:0]          recov_inc;
	logic [wfhm_pkg::RES_W-1:0]     neg_res;
	logic [wfhm_pkg::MAG_W-1:0]     mag;

	assign cnt_max_w = CW'({COUNT_BITS{1'b1}});
	assign fault_n_w = CW'(cfg.fault_samples);
	assign recov_n_w = CW'(cfg.recovery_samples);

	// lost sensor loads the fault count with the sample target, saturated
	assign fault_load = (fault_n_w > cnt_max_w) ? {COUNT_BITS{1'b1}}
	                                            : fault_n_w[COUNT_BITS-1:0];

	assign fault_inc = (&fault_ev_cur) ? fault_ev_cur : fault_ev_cur + COUNT_BITS'(1);
	assign recov_inc = (&recov_ev_cur) ? recov_ev_cur : recov_ev_cur + COUNT_BITS'(1);

	// magnitude saturates for the most negative residual
	assign neg_res = wfhm_pkg::RES_W'(0) - residual;
	always_comb begin
		if (!residual[wfhm_pkg::RES_W-1]) begin
			mag = residual[wfhm_pkg::MAG_W-1:0];
		end else if (neg_res[wfhm_pkg::RES_W-1]) begin
			mag = '1;
		end else begin
			mag = neg_res[wfhm_pkg::MAG_W-1:0];
		end
	end

	always_comb begin
		faulted_nxt  = faulted_cur;
		fault_ev_nxt = fault_ev_cur;
		recov_ev_nxt = recov_ev_cur;
		mag_nxt      = mag_cur;
		unique case (cmd)
			wfhm_pkg::CMD_UPDATE: begin
				mag_nxt = mag;
				if (!sensor_ok) begin
					faulted_nxt  = 1'b1;
					fault_ev_nxt = fault_load;
					recov_ev_nxt = '0;
				end else if (!faulted_cur) begin
					recov_ev_nxt = '0;
					if (mag >= cfg.fault_threshold) begin
						fault_ev_nxt = fault_inc;
						if (CW'(fault_inc) >= fault_n_w) begin
							faulted_nxt = 1'b1;
						end
					end else begin
						fault_ev_nxt = '0;
					end
				end else begin
					fault_ev_nxt = '0;
					if (mag <= cfg.recovery_threshold) begin
						recov_ev_nxt = recov_inc;
						if (CW'(recov_inc) >= recov_n_w) begin
							faulted_nxt  = 1'b0;
							recov_ev_nxt = '0;
						end
					end else begin
						recov_ev_nxt = '0;
					end
				end
			end
			wfhm_pkg::CMD_RESET: begin
				faulted_nxt  = !reset_healthy;
				fault_ev_nxt = '0;
				recov_ev_nxt = '0;
				mag_nxt      = '0;
			end
			default: begin
				// query and the spare code leave the wheel as it is
			end
		endcase
	end

endmodule

`default_nettype wire

// File: rtl/wheel_fault_hysteresis_monitor.sv
// Per-wheel fault monitor with hysteresis and debounce.
// Input channel (in_valid/in_ready) carries cmd, wheel, residual, sensor_ok and
// reset_healthy; each transfer yields exactly one result on the output
// channel (out_valid/out_ready): status, wheel_available, residual_magnitude,
// fault_count and recovery_count of the addressed wheel after the step.
// An item transferred into the input register is worked through combinationally
// into the result register, where out_valid rises. Throughput is one item per
// cycle while the receiver takes results; the wheel state lives in flip-flops
// so an item sees the state left by the one just before it. Registers are
// written over cfg_wr_en/cfg_index/cfg_data; the user must write them only
// while idle, and the block does not enforce it. Reset clears every wheel
// (healthy, counters and magnitude zero) and loads the register defaults; no
// item is in flight after reset. When the receiver stalls the result register
// holds and the input register fills; in_ready then drops until out_ready
// returns.
`default_nettype none

module wheel_fault_hysteresis_monitor #(
	parameter int MAX_WHEELS = wfhm_pkg::MAX_WHEELS_DEF,
	parameter int COUNT_BITS = wfhm_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_wr_en,
	input  wire logic [wfhm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [wfhm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [1:0]                          cmd,
	input  wire logic [wfhm_pkg::WHEEL_W-1:0]        wheel,
	input  wire logic signed [wfhm_pkg::RES_W-1:0]   residual,
	input  wire logic                                sensor_ok,
	input  wire logic                                reset_healthy,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic [1:0]                               status,
	output logic                                     wheel_available,
	output logic [wfhm_pkg::MAG_W-1:0]               residual_magnitude,
	output logic [wfhm_pkg::CNT_OUT_W-1:0]           fault_count,
	output logic [wfhm_pkg::CNT_OUT_W-1:0]           recovery_count
);

	localparam int WIDX_W = (MAX_WHEELS > 1) ? $clog2(MAX_WHEELS) : 1;
	localparam int MAXW_W = $clog2(MAX_WHEELS + 1);
	localparam int CMP_W  = (MAXW_W > wfhm_pkg::NWHEEL_W) ? MAXW_W : wfhm_pkg::NWHEEL_W;

	wfhm_pkg::cfg_t cfg;

	wfhm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// input register
	logic                            valid_s1;
	wfhm_pkg::cmd_t                  cmd_s1;
	logic [wfhm_pkg::WHEEL_W-1:0]    wheel_s1;
	logic [wfhm_pkg::RES_W-1:0]      residual_s1;
	logic                            sensor_ok_s1;
	logic                            healthy_s1;

	// wheel state
	logic [MAX_WHEELS-1:0]           faulted_q;
	logic [COUNT_BITS-1:0]           fault_ev_q [MAX_WHEELS];
	logic [COUNT_BITS-1:0]           recov_ev_q [MAX_WHEELS];
	logic [wfhm_pkg::MAG_W-1:0]      last_mag_q [MAX_WHEELS];

	// result register
	logic                            out_valid_q;
	wfhm_pkg::status_t               status_q;
	logic                            wheel_avail_q;
	logic [wfhm_pkg::MAG_W-1:0]      res_mag_q;
	logic [wfhm_pkg::CNT_OUT_W-1:0]  fault_cnt_q;
	logic [wfhm_pkg::CNT_OUT_W-1:0]  recov_cnt_q;

	logic                            advance;
	logic [WIDX_W-1:0]               widx;
	logic [CMP_W-1:0]                n_eff;
	logic                            in_range;
	logic                            faulted_nxt;
	logic [COUNT_BITS-1:0]           fault_ev_nxt;
	logic [COUNT_BITS-1:0]           recov_ev_nxt;
	logic [wfhm_pkg::MAG_W-1:0]      mag_nxt;
	logic                            degraded;

	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1       <= wfhm_pkg::cmd_t'(cmd);
			wheel_s1     <= wheel;
			residual_s1  <= residual;
			sensor_ok_s1 <= sensor_ok;
			healthy_s1   <= reset_healthy;
		end
	end

	// wheel count above the maximum acts as the maximum
	assign n_eff = (CMP_W'(cfg.wheels_in_use) > CMP_W'(MAX_WHEELS)) ? CMP_W'(MAX_WHEELS)
	                                                                 : CMP_W'(cfg.wheels_in_use);
	assign in_range = CMP_W'(wheel_s1) < n_eff;
	assign widx     = WIDX_W'(wheel_s1);

	wfhm_step #(
		.COUNT_BITS (COUNT_BITS)
	) u_step (
		.cfg              (cfg),
		.cmd              (cmd_s1),
		.residual         (residual_s1),
		.sensor_ok        (sensor_ok_s1),
		.reset_healthy    (healthy_s1),
		.faulted_cur      (faulted_q[widx]),
		.fault_ev_cur     (fault_ev_q[widx]),
		.recov_ev_cur     (recov_ev_q[widx]),
		.mag_cur          (last_mag_q[widx]),
		.faulted_nxt      (faulted_nxt),
		.fault_ev_nxt     (fault_ev_nxt),
		.recov_ev_nxt     (recov_ev_nxt),
		.mag_nxt          (mag_nxt)
	);

	// degraded status sees the addressed wheel after this step
	always_comb begin
		degraded = 1'b0;
		for (int i = 0; i < MAX_WHEELS; i++) begin
			if (CMP_W'(i) < n_eff) begin
				if (WIDX_W'(i) == widx) begin
					degraded = degraded | faulted_nxt;
				end else begin
					degraded = degraded | faulted_q[i];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WHEELS; i++) begin
				faulted_q[i]  <= 1'b0;
				fault_ev_q[i] <= '0;
				recov_ev_q[i] <= '0;
				last_mag_q[i] <= '0;
			end
		end else if (advance && in_range) begin
			faulted_q[widx]  <= faulted_nxt;
			fault_ev_q[widx] <= fault_ev_nxt;
			recov_ev_q[widx] <= recov_ev_nxt;
			last_mag_q[widx] <= mag_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (in_range) begin
				status_q      <= degraded ? wfhm_pkg::STATUS_DEGRADED : wfhm_pkg::STATUS_OK;
				wheel_avail_q <= !faulted_nxt;
				res_mag_q     <= mag_nxt;
				fault_cnt_q   <= wfhm_pkg::CNT_OUT_W'(fault_ev_nxt);
				recov_cnt_q   <= wfhm_pkg::CNT_OUT_W'(recov_ev_nxt);
			end else begin
				status_q      <= wfhm_pkg::STATUS_RANGE;
				wheel_avail_q <= 1'b0;
				res_mag_q     <= '0;
				fault_cnt_q   <= '0;
				recov_cnt_q   <= '0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign wheel_available    = wheel_avail_q;
	assign residual_magnitude = res_mag_q;
	assign fault_count        = fault_cnt_q;
	assign recovery_count     = recov_cnt_q;

endmodule

`default_nettype wire

// File: bench/wheel_fault_hysteresis_monitor_tb.sv
module wheel_fault_hysteresis_monitor_tb;

	localparam int CLK_HIGH       = 6;
	localparam int CLK_LOW        = 6;
	localparam int CLK_PERIOD     = CLK_HIGH + CLK_LOW;
	localparam int RESET_CYCLES   = 6;
	localparam int TIMEOUT_CYCLES = 1000000;
	localparam int DRAIN_LIMIT    = 20000;
	localparam int SETTLE_CYCLES  = 4;
	localparam int LONG_HOLD      = 300;
	localparam int PRESSURE_ITEMS = 40;
	localparam int ITEMS_PER_MODE = 65;
	localparam int NUM_PROBES     = 25;
	localparam int NUM_TRIALS     = 7;
	localparam int NUM_MODES      = 4;
	localparam int MAX_WHEELS     = wfhm_pkg::MAX_WHEELS_DEF;
	localparam logic [2:0] SAT_WHEEL = 3'd5;

	typedef struct packed {
		wfhm_pkg::status_t                    status;
		logic                                 available;
		logic [wfhm_pkg::MAG_W-1:0]           magnitude;
		logic [wfhm_pkg::CNT_OUT_W-1:0]       fault_cnt;
		logic [wfhm_pkg::CNT_OUT_W-1:0]       recov_cnt;
	} wheel_report_t;

	typedef struct packed {
		wfhm_pkg::cmd_t                   op;
		logic [wfhm_pkg::WHEEL_W-1:0]     whl;
		logic [wfhm_pkg::RES_W-1:0]       res;
		logic                             ok;
		logic                             avail;
		logic                             typed;
		wheel_report_t                    want;
	} probe_row_t;

	logic                                   clk = 1'b0;
	logic                                   arst_n;
	logic                                   cfg_wr_en;
	logic [wfhm_pkg::CFG_IDX_W-1:0]         cfg_index;
	logic [wfhm_pkg::CFG_DATA_W-1:0]        cfg_data;
	logic                                   in_valid;
	logic                                   in_ready;
	logic [1:0]                             cmd;
	logic [wfhm_pkg::WHEEL_W-1:0]           wheel;
	logic signed [wfhm_pkg::RES_W-1:0]      residual;
	logic                                   sensor_ok;
	logic                                   reset_healthy;
	logic                                   out_valid;
	logic                                   out_ready;
	logic [1:0]                             status;
	logic                                   wheel_available;
	logic [wfhm_pkg::MAG_W-1:0]             residual_magnitude;
	logic [wfhm_pkg::CNT_OUT_W-1:0]         fault_count;
	logic [wfhm_pkg::CNT_OUT_W-1:0]         recovery_count;

	// shadow of the block: register settings and per-wheel state
	wfhm_pkg::cfg_t                 cur_cfg = wfhm_pkg::CFG_RESET;
	logic                           faulted_st [MAX_WHEELS] = '{default: 1'b0};
	logic [wfhm_pkg::SAMP_W-1:0]    fault_ev   [MAX_WHEELS] = '{default: '0};
	logic [wfhm_pkg::SAMP_W-1:0]    recov_ev   [MAX_WHEELS] = '{default: '0};
	logic [wfhm_pkg::MAG_W-1:0]     mag_st     [MAX_WHEELS] = '{default: '0};

	wheel_report_t expected_reports [$];

	int mismatches       = 0;
	int items_sent       = 0;
	int results_checked  = 0;
	int settings_applied = 0;
	int send_idle_pct    = 0;
	int stall_pct        = 0;
	int hold_req         = 0;
	int hold_seen;
	int hold_left;

	int send_idle_by_mode [NUM_MODES] = '{0, 48, 0, 28};
	int stall_by_mode     [NUM_MODES] = '{0, 0, 48, 28};

	wheel_fault_hysteresis_monitor u_top (.*);

	always begin
		#CLK_HIGH clk = 1'b1;
		#CLK_LOW clk = 1'b0;
	end

	initial begin
		#(CLK_PERIOD * TIMEOUT_CYCLES);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic logic [wfhm_pkg::SAMP_W-1:0] sat_inc(logic [wfhm_pkg::SAMP_W-1:0] c);
		return (c == '1) ? c : c + 1'b1;
	endfunction

	function automatic logic [wfhm_pkg::NWHEEL_W-1:0] wheels_effective();
		return (cur_cfg.wheels_in_use > MAX_WHEELS) ? wfhm_pkg::NWHEEL_W'(MAX_WHEELS)
			: cur_cfg.wheels_in_use;
	endfunction

	// one item through the shadow state, giving the report the block should send
	function automatic wheel_report_t advance_wheel(wfhm_pkg::cmd_t op,
		logic [wfhm_pkg::WHEEL_W-1:0] whl, logic [wfhm_pkg::RES_W-1:0] res, logic ok,
		logic avail);
		wheel_report_t                  rep;
		logic [wfhm_pkg::NWHEEL_W-1:0]  n_eff;
		logic [wfhm_pkg::RES_W-1:0]     neg;
		logic [wfhm_pkg::MAG_W-1:0]     mag;
		logic                           degraded;
		rep = '0;
		n_eff = wheels_effective();
		if ({1'b0, whl} >= n_eff) begin
			rep.status = wfhm_pkg::STATUS_RANGE;
			return rep;
		end
		case (op)
			wfhm_pkg::CMD_UPDATE: begin
				neg = ~res + 1'b1;
				// most negative input has no positive twin, clamp it
				if (res[wfhm_pkg::RES_W-1])
					mag = neg[wfhm_pkg::RES_W-1] ? '1 : neg[wfhm_pkg::MAG_W-1:0];
				else
					mag = res[wfhm_pkg::MAG_W-1:0];
				mag_st[whl] = mag;
				if (!ok) begin
					faulted_st[whl] = 1'b1;
					fault_ev[whl] = cur_cfg.fault_samples;
					recov_ev[whl] = '0;
				end else if (!faulted_st[whl]) begin
					recov_ev[whl] = '0;
					if (mag >= cur_cfg.fault_threshold) begin
						fault_ev[whl] = sat_inc(fault_ev[whl]);
						if (fault_ev[whl] >= cur_cfg.fault_samples)
							faulted_st[whl] = 1'b1;
					end else begin
						fault_ev[whl] = '0;
					end
				end else begin
					fault_ev[whl] = '0;
					if (mag <= cur_cfg.recovery_threshold) begin
						recov_ev[whl] = sat_inc(recov_ev[whl]);
						if (recov_ev[whl] >= cur_cfg.recovery_samples) begin
							faulted_st[whl] = 1'b0;
							recov_ev[whl] = '0;
						end
					end else begin
						recov_ev[whl] = '0;
					end
				end
			end
			wfhm_pkg::CMD_RESET: begin
				faulted_st[whl] = !avail;
				fault_ev[whl] = '0;
				recov_ev[whl] = '0;
				mag_st[whl] = '0;
			end
			default: ;
		endcase
		degraded = 1'b0;
		for (int i = 0; i < MAX_WHEELS; i++)
			if (i < n_eff && faulted_st[i])
				degraded = 1'b1;
		if (degraded)
			rep.status = wfhm_pkg::STATUS_DEGRADED;
		else
			rep.status = wfhm_pkg::STATUS_OK;
		rep.available = !faulted_st[whl];
		rep.magnitude = mag_st[whl];
		rep.fault_cnt = fault_ev[whl];
		rep.recov_cnt = recov_ev[whl];
		return rep;
	endfunction

	function automatic probe_row_t probe_row(wfhm_pkg::cmd_t op,
		logic [wfhm_pkg::WHEEL_W-1:0] whl, logic [wfhm_pkg::RES_W-1:0] res, logic ok,
		logic avail, logic typed, wfhm_pkg::status_t st, logic av,
		logic [wfhm_pkg::MAG_W-1:0] mg, logic [wfhm_pkg::CNT_OUT_W-1:0] fc,
		logic [wfhm_pkg::CNT_OUT_W-1:0] rc);
		probe_row_t row;
		row.op = op;
		row.whl = whl;
		row.res = res;
		row.ok = ok;
		row.avail = avail;
		row.typed = typed;
		row.want.status = st;
		row.want.available = av;
		row.want.magnitude = mg;
		row.want.fault_cnt = fc;
		row.want.recov_cnt = rc;
		return row;
	endfunction

	task automatic offer_item(wfhm_pkg::cmd_t op, logic [wfhm_pkg::WHEEL_W-1:0] whl,
		logic [wfhm_pkg::RES_W-1:0] res, logic ok, logic avail, logic typed,
		wheel_report_t typed_rep);
		wheel_report_t pred;
		if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		in_valid <= 1'b1;
		cmd <= op;
		wheel <= whl;
		residual <= res;
		sensor_ok <= ok;
		reset_healthy <= avail;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = advance_wheel(op, whl, res, ok, avail);
		expected_reports.push_back(typed ? typed_rep : pred);
		items_sent++;
	endtask

	// residuals are mostly steered towards the threshold the wheel must cross next
	task automatic offer_random_item();
		wfhm_pkg::cmd_t                 op;
		logic [wfhm_pkg::WHEEL_W-1:0]   whl;
		logic [wfhm_pkg::RES_W-1:0]     res;
		logic [wfhm_pkg::NWHEEL_W-1:0]  n_eff;
		logic                           ok;
		logic                           toward_low;
		int unsigned                    pick;
		longint                         lvl;
		n_eff = wheels_effective();
		pick = $urandom_range(99);
		if (pick < 72)
			op = wfhm_pkg::CMD_UPDATE;
		else if (pick < 82)
			op = wfhm_pkg::CMD_RESET;
		else if (pick < 92)
			op = wfhm_pkg::CMD_QUERY;
		else
			op = wfhm_pkg::CMD_SPARE;
		if (n_eff != 0 && $urandom_range(99) < 85)
			whl = wfhm_pkg::WHEEL_W'($urandom_range(int'(n_eff) - 1));
		else
			whl = wfhm_pkg::WHEEL_W'($urandom_range(MAX_WHEELS - 1));
		toward_low = faulted_st[whl];
		pick = $urandom_range(99);
		if (pick < 75) begin
			if (pick >= 60)
				toward_low = !toward_low;
			if (toward_low) begin
				lvl = cur_cfg.recovery_threshold;
				lvl = lvl + int'($urandom_range(5)) - 4;
			end else begin
				lvl = cur_cfg.fault_threshold;
				lvl = lvl + int'($urandom_range(5)) - 1;
			end
			if (lvl < 0)
				lvl = 0;
			if (lvl > 64'h7FFF_FFFF)
				lvl = 64'h7FFF_FFFF;
			res = lvl[wfhm_pkg::RES_W-1:0];
			if ($urandom_range(1))
				res = ~res + 1'b1;
		end else if (pick < 85) begin
			case ($urandom_range(4))
				0: res = 32'h8000_0000;
				1: res = 32'h7FFF_FFFF;
				2: res = 32'h0000_0000;
				3: res = 32'hFFFF_FFFF;
				default: res = 32'h8000_0001;
			endcase
		end else begin
			res = $urandom;
		end
		ok = ($urandom_range(99) < 92);
		offer_item(op, whl, res, ok, 1'($urandom_range(1)), 1'b0, '0);
	endtask

	task automatic drain_results();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (expected_reports.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(wfhm_pkg::cfg_t s);
		wfhm_pkg::cfg_reg_t idx;
		for (int i = wfhm_pkg::REG_WHEELS; i <= wfhm_pkg::REG_RECOV_N; i++) begin
			idx = wfhm_pkg::cfg_reg_t'(i);
			cfg_wr_en <= 1'b1;
			cfg_index <= idx;
			case (idx)
				wfhm_pkg::REG_WHEELS:   cfg_data <= {27'd0, s.wheels_in_use};
				wfhm_pkg::REG_FAULT_TH: cfg_data <= s.fault_threshold;
				wfhm_pkg::REG_RECOV_TH: cfg_data <= s.recovery_threshold;
				wfhm_pkg::REG_FAULT_N:  cfg_data <= {15'd0, s.fault_samples};
				default:                cfg_data <= {15'd0, s.recovery_samples};
			endcase
			@(posedge clk);
		end
		cfg_wr_en <= 1'b0;
		cur_cfg = s;
		settings_applied++;
	endtask

	// result side: random back-pressure, plus a long hold-off on request
	initial begin
		wheel_report_t want;
		out_ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (expected_reports.size() == 0) begin
					$error("result transfer with no expectation pending");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					results_checked++;
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (wheel_available !== want.available) begin
						$error("wheel_available: expected %0d, got %0d", want.available,
							wheel_available);
						mismatches++;
					end
					if (residual_magnitude !== want.magnitude) begin
						$error("residual_magnitude: expected %0h, got %0h", want.magnitude,
							residual_magnitude);
						mismatches++;
					end
					if (fault_count !== want.fault_cnt) begin
						$error("fault_count: expected %0d, got %0d", want.fault_cnt,
							fault_count);
						mismatches++;
					end
					if (recovery_count !== want.recov_cnt) begin
						$error("recovery_count: expected %0d, got %0d", want.recov_cnt,
							recovery_count);
						mismatches++;
					end
				end
			end
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		probe_row_t      probes [NUM_PROBES];
		wfhm_pkg::cfg_t  trial_cfgs [NUM_TRIALS];
		wfhm_pkg::cfg_t  sat_cfg;

		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = wfhm_pkg::REG_WHEELS;
		cfg_data = '0;
		in_valid = 1'b0;
		cmd = wfhm_pkg::CMD_QUERY;
		wheel = '0;
		residual = '0;
		sensor_ok = 1'b0;
		reset_healthy = 1'b0;

		// register defaults in force: four wheels, fault at 0.5, recover at 0.2
		probes[0]  = probe_row(wfhm_pkg::CMD_QUERY,  3'd0, 32'd0, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_OK, 1'b1, 31'd0, 16'd0, 16'd0);
		probes[1]  = probe_row(wfhm_pkg::CMD_QUERY,  3'd7, 32'd0, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_RANGE, 1'b0, 31'd0, 16'd0, 16'd0);
		probes[2]  = probe_row(wfhm_pkg::CMD_UPDATE, 3'd7, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_RANGE, 1'b0, 31'd0, 16'd0, 16'd0);
		probes[3]  = probe_row(wfhm_pkg::CMD_UPDATE, 3'd0, 32'h8000_0000, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_OK, 1'b1, 31'h7FFF_FFFF, 16'd1, 16'd0);
		probes[4]  = probe_row(wfhm_pkg::CMD_UPDATE, 3'd0, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_OK, 1'b1, 31'h7FFF_FFFF, 16'd2, 16'd0);
		probes[5]  = probe_row(wfhm_pkg::CMD_UPDATE, 3'd0, 32'hFFFF_8000, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_DEGRADED, 1'b0, 31'd32768, 16'd3, 16'd0);
		probes[6]  = probe_row(wfhm_pkg::CMD_UPDATE, 3'd0, 32'd13107, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_DEGRADED, 1'b0, 31'd13107, 16'd0, 16'd1);
		probes[7]  = probe_row(wfhm_pkg::CMD_UPDATE, 3'd0, 32'd13108, 1'b1, 1'b0, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		for (int i = 8; i < 13; i++)
			probes[i] = probe_row(wfhm_pkg::CMD_UPDATE, 3'd0, 32'hFFFF_CCCD, 1'b1, 1'b0,
				1'b0, wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		probes[13] = probe_row(wfhm_pkg::CMD_UPDATE, 3'd1, 32'd0, 1'b0, 1'b0, 1'b1,
			wfhm_pkg::STATUS_DEGRADED, 1'b0, 31'd0, 16'd3, 16'd0);
		probes[14] = probe_row(wfhm_pkg::CMD_RESET,  3'd1, 32'd0, 1'b1, 1'b1, 1'b1,
			wfhm_pkg::STATUS_OK, 1'b1, 31'd0, 16'd0, 16'd0);
		probes[15] = probe_row(wfhm_pkg::CMD_RESET,  3'd2, 32'd0, 1'b1, 1'b0, 1'b1,
			wfhm_pkg::STATUS_DEGRADED, 1'b0, 31'd0, 16'd0, 16'd0);
		probes[16] = probe_row(wfhm_pkg::CMD_SPARE,  3'd2, 32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1,
			wfhm_pkg::STATUS_DEGRADED, 1'b0, 31'd0, 16'd0, 16'd0);
		probes[17] = probe_row(wfhm_pkg::CMD_QUERY,  3'd2, 32'd0, 1'b1, 1'b0, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		probes[18] = probe_row(wfhm_pkg::CMD_UPDATE, 3'd3, 32'd32767, 1'b1, 1'b0, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		probes[19] = probe_row(wfhm_pkg::CMD_UPDATE, 3'd3, 32'd32768, 1'b1, 1'b0, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		probes[20] = probe_row(wfhm_pkg::CMD_RESET,  3'd3, 32'd0, 1'b1, 1'b0, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		probes[21] = probe_row(wfhm_pkg::CMD_RESET,  3'd2, 32'd0, 1'b1, 1'b1, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		probes[22] = probe_row(wfhm_pkg::CMD_RESET,  3'd3, 32'd0, 1'b1, 1'b1, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);
		// wheel four is outside the default count and must stay untouched
		probes[23] = probe_row(wfhm_pkg::CMD_UPDATE, 3'd4, 32'h8000_0000, 1'b0, 1'b0, 1'b1,
			wfhm_pkg::STATUS_RANGE, 1'b0, 31'd0, 16'd0, 16'd0);
		probes[24] = probe_row(wfhm_pkg::CMD_QUERY,  3'd3, 32'd0, 1'b1, 1'b0, 1'b0,
			wfhm_pkg::STATUS_OK, 1'b0, '0, '0, '0);

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_PROBES; k++)
			offer_item(probes[k].op, probes[k].whl, probes[k].res, probes[k].ok,
				probes[k].avail, probes[k].typed, probes[k].want);
		drain_results();

		// output held off for a long stretch while the input keeps offering
		send_idle_pct = 0;
		hold_req <= hold_req + 1;
		repeat (PRESSURE_ITEMS) offer_random_item();
		drain_results();

		trial_cfgs[0] = wfhm_pkg::CFG_RESET;
		trial_cfgs[1] = '{wheels_in_use: 4'd8, fault_threshold: 31'd1,
			recovery_threshold: 31'd0, fault_samples: 16'd1, recovery_samples: 16'd1};
		trial_cfgs[2] = '{wheels_in_use: 4'd15, fault_threshold: 31'h7FFF_FFFF,
			recovery_threshold: 31'h7FFF_FFFE, fault_samples: 16'd0, recovery_samples: 16'd0};
		trial_cfgs[3] = '{wheels_in_use: 4'd0, fault_threshold: 31'd32768,
			recovery_threshold: 31'd13107, fault_samples: 16'd2, recovery_samples: 16'd2};
		trial_cfgs[4] = '{wheels_in_use: 4'd1, fault_threshold: 31'd100000,
			recovery_threshold: 31'd50000, fault_samples: 16'd2, recovery_samples: 16'd7};
		trial_cfgs[5] = '{wheels_in_use: 4'd6, fault_threshold: 31'd65536,
			recovery_threshold: 31'd65536, fault_samples: 16'd4, recovery_samples: 16'd3};
		trial_cfgs[6].wheels_in_use = wfhm_pkg::NWHEEL_W'($urandom_range(15, 1));
		trial_cfgs[6].fault_threshold = wfhm_pkg::MAG_W'($urandom_range(32'h7FFF_FFFF, 1));
		trial_cfgs[6].recovery_threshold = wfhm_pkg::MAG_W'($urandom_range(32'h7FFF_FFFE, 0));
		trial_cfgs[6].fault_samples = wfhm_pkg::SAMP_W'($urandom_range(6, 1));
		trial_cfgs[6].recovery_samples = wfhm_pkg::SAMP_W'($urandom_range(6, 0));

		for (int s = 0; s < NUM_TRIALS; s++) begin
			apply_settings(trial_cfgs[s]);
			for (int m = 0; m < NUM_MODES; m++) begin
				send_idle_pct = send_idle_by_mode[m];
				stall_pct <= stall_by_mode[m];
				repeat (ITEMS_PER_MODE) offer_random_item();
			end
			drain_results();
		end

		// full-scale sample targets: a lost sensor loads the fault count to the top
		sat_cfg = '{wheels_in_use: 4'd8, fault_threshold: 31'd1,
			recovery_threshold: 31'h7FFF_FFFE, fault_samples: 16'hFFFF,
			recovery_samples: 16'hFFFF};
		apply_settings(sat_cfg);
		send_idle_pct = 0;
		stall_pct <= 0;
		offer_item(wfhm_pkg::CMD_UPDATE, SAT_WHEEL, 32'h7FFF_FFFF, 1'b1, 1'b0, 1'b0, '0);
		offer_item(wfhm_pkg::CMD_UPDATE, SAT_WHEEL, 32'd0, 1'b0, 1'b0, 1'b0, '0);
		offer_item(wfhm_pkg::CMD_UPDATE, SAT_WHEEL, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, '0);
		offer_item(wfhm_pkg::CMD_QUERY, SAT_WHEEL, 32'd0, 1'b1, 1'b0, 1'b0, '0);
		drain_results();

		if (expected_reports.size() != 0) begin
			$error("%0d expected results never arrived", expected_reports.size());
			mismatches++;
		end
		$display("run covered %0d items over %0d register settings, %0d results compared,",
			items_sent, settings_applied, results_checked);
		$display("with random idling on both sides, a long output hold-off and full-scale targets");
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
